// File: rtl/core/mvw_pkg.sv
// Shared types and constants for the mesh vertex weld core.
// Used by mvw_cell and mesh_vertex_weld_core. No dependencies.
package mvw_pkg;

  localparam int MAX_VERTICES = 4096;
  localparam int ADDR_W       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int NUM_AXES     = 3;
  localparam int COORD_W      = 24;
  localparam int DIFF_W       = COORD_W + 1;
  localparam int SQ_W         = 2 * COORD_W + 1;
  localparam int DIST_W       = 50;
  localparam int IDX_W        = 12;
  localparam int VTX_W        = NUM_AXES * COORD_W;
  localparam int MIN_SEARCH   = 3;

  localparam logic [CNT_W-1:0]  MAX_CNT     = CNT_W'(MAX_VERTICES);
  localparam logic [DIST_W-1:0] MERGE_RESET = DIST_W'(16);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef coord_t [NUM_AXES-1:0] vertex_t;
  typedef logic [DIST_W-1:0] dist_t;

  typedef struct packed {
    logic               new_mesh;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
  } in_beat_t;

  typedef struct packed {
    logic [IDX_W-1:0] vertex_index;
    logic             is_new;
    logic             table_full;
  } out_beat_t;

  typedef struct packed {
    logic              valid;
    logic              last;
    logic [ADDR_W-1:0] idx;
  } tag_t;

  typedef struct packed {
    logic load;
    logic flush;
  } cell_ctl_t;

  function automatic logic [IDX_W-1:0] to_index(input logic [ADDR_W-1:0] a);
    logic [31:0] t;
    t = 32'(a);
    return t[IDX_W-1:0];
  endfunction

endpackage

// File: rtl/core/mvw_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mvw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/mvw_cell.sv
// One axis cell of the distance chain: holds its probe coordinate, adds the
// squared axis difference to the running sum, passes the beat on. Uses mvw_pkg.
module mvw_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  mvw_pkg::cell_ctl_t ctl,
  input  mvw_pkg::coord_t   probe_in,
  input  mvw_pkg::coord_t   coord_in,
  input  mvw_pkg::vertex_t  row_in,
  input  mvw_pkg::dist_t    sum_in,
  input  mvw_pkg::tag_t     tag_in,
  output mvw_pkg::vertex_t  row_out,
  output mvw_pkg::dist_t    sum_out,
  output mvw_pkg::tag_t     tag_out
);
  import mvw_pkg::*;

  coord_t                    probe_r;
  logic signed [DIFF_W-1:0]  diff_r;
  logic signed [DIFF_W-1:0]  diff_nxt;
  logic [SQ_W-1:0]           sq_r;
  logic [SQ_W-1:0]           sq_nxt;
  logic signed [2*DIFF_W-1:0] prod;
  dist_t                     sum_r [3];
  dist_t                     sum_nxt;
  vertex_t                   row_r [3];
  tag_t                      tag_r [3];

  assign diff_nxt = DIFF_W'(probe_r) - DIFF_W'(coord_in);
  assign prod     = diff_r * diff_r;
  assign sq_nxt   = prod[SQ_W-1:0];
  assign sum_nxt  = sum_r[1] + DIST_W'(sq_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r[0] <= '0;
      tag_r[1] <= '0;
      tag_r[2] <= '0;
    end else if (ctl.flush) begin
      tag_r[0] <= '0;
      tag_r[1] <= '0;
      tag_r[2] <= '0;
    end else begin
      tag_r[0] <= tag_in;
      tag_r[1] <= tag_r[0];
      tag_r[2] <= tag_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      probe_r <= probe_in;
    end
    diff_r   <= diff_nxt;
    sq_r     <= sq_nxt;
    sum_r[0] <= sum_in;
    sum_r[1] <= sum_r[0];
    sum_r[2] <= sum_nxt;
    row_r[0] <= row_in;
    row_r[1] <= row_r[0];
    row_r[2] <= row_r[1];
  end

  assign row_out = row_r[2];
  assign sum_out = sum_r[2];
  assign tag_out = tag_r[2];

endmodule

// File: rtl/core/mesh_vertex_weld_core.sv
// Mesh vertex weld core: scan controller, vertex RAM and three-cell distance chain.
// Uses mvw_pkg, mvw_ram and mvw_cell.
//
// One corner is taken when start is high and busy is low; its result comes
// as a one-cycle out_valid strobe that the receiver must take at once. While
// the table holds fewer than three vertices the corner goes to ST_APPEND and
// its result is registered there. Otherwise the vertex RAM is read one entry
// per cycle into a ten-stage chain (RAM read plus three axis cells of three
// stages each): a match at entry j ends the scan with index j; on a miss the
// corner is appended after the last entry leaves the chain. busy stays high
// until the result is registered, and the next corner may be taken in the
// cycle the strobe is shown. Threshold writes on cfg are taken any time.
module mesh_vertex_weld_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  mvw_pkg::in_beat_t  in_data,
  output logic               out_valid,
  output mvw_pkg::out_beat_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  mvw_pkg::dist_t     cfg_data
);
  import mvw_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_WAIT   = 2'd2;
  localparam logic [1:0] ST_APPEND = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt, count_eff;
  dist_t             thr_r;
  vertex_t           vtx_r;
  vertex_t           in_vtx;
  tag_t              tag_rd_r;
  tag_t              iss;
  logic              out_valid_r, out_valid_nxt;
  out_beat_t         out_data_r, out_data_nxt;
  logic              accept;
  logic              match;
  logic              ram_we;
  vertex_t           rd_data;
  cell_ctl_t         ctl;

  vertex_t row_s [NUM_AXES];
  dist_t   sum_s [NUM_AXES+1];
  tag_t    tag_s [NUM_AXES+1];

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  assign in_vtx[0] = in_data.pos_x;
  assign in_vtx[1] = in_data.pos_y;
  assign in_vtx[2] = in_data.pos_z;

  assign match     = tag_s[NUM_AXES].valid && (sum_s[NUM_AXES] < thr_r);
  assign ctl.load  = accept;
  assign ctl.flush = match;

  assign iss.valid = (state_r == ST_SCAN) && !match;
  assign iss.last  = ((CNT_W'(addr_r) + CNT_W'(1)) == count_r);
  assign iss.idx   = addr_r;

  assign ram_we    = (state_r == ST_APPEND) && (count_r < MAX_CNT);

  mvw_ram #(
    .WIDTH (VTX_W),
    .DEPTH (MAX_VERTICES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[ADDR_W-1:0]),
    .wdata (vtx_r),
    .raddr (addr_r),
    .rdata (rd_data)
  );

  assign row_s[0] = rd_data;
  assign sum_s[0] = '0;
  assign tag_s[0] = tag_rd_r;

  for (genvar k = 0; k < NUM_AXES; k++) begin : g_cell
    if (k < NUM_AXES - 1) begin : g_mid
      mvw_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .probe_in (in_vtx[k]),
        .coord_in (row_s[k][k]),
        .row_in   (row_s[k]),
        .sum_in   (sum_s[k]),
        .tag_in   (tag_s[k]),
        .row_out  (row_s[k+1]),
        .sum_out  (sum_s[k+1]),
        .tag_out  (tag_s[k+1])
      );
    end else begin : g_end
      mvw_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .probe_in (in_vtx[k]),
        .coord_in (row_s[k][k]),
        .row_in   (row_s[k]),
        .sum_in   (sum_s[k]),
        .tag_in   (tag_s[k]),
        .row_out  (),
        .sum_out  (sum_s[k+1]),
        .tag_out  (tag_s[k+1])
      );
    end
  end

  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    count_nxt     = count_r;
    count_eff     = in_data.new_mesh ? '0 : count_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          count_nxt = count_eff;
          addr_nxt  = '0;
          state_nxt = (count_eff < CNT_W'(MIN_SEARCH)) ? ST_APPEND : ST_SCAN;
        end
      end
      ST_SCAN, ST_WAIT: begin
        if (match) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.vertex_index = to_index(tag_s[NUM_AXES].idx);
          out_data_nxt.is_new       = 1'b0;
          out_data_nxt.table_full   = 1'b0;
          state_nxt                 = ST_IDLE;
        end else if (state_r == ST_SCAN) begin
          addr_nxt = addr_r + ADDR_W'(1);
          if (iss.last) begin
            state_nxt = ST_WAIT;
          end
        end else if (tag_s[NUM_AXES].valid && tag_s[NUM_AXES].last) begin
          state_nxt = ST_APPEND;
        end
      end
      ST_APPEND: begin
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
        if (count_r < MAX_CNT) begin
          out_data_nxt.vertex_index = to_index(count_r[ADDR_W-1:0]);
          out_data_nxt.is_new       = 1'b1;
          out_data_nxt.table_full   = 1'b0;
          count_nxt                 = count_r + CNT_W'(1);
        end else begin
          out_data_nxt.vertex_index = '0;
          out_data_nxt.is_new       = 1'b0;
          out_data_nxt.table_full   = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      addr_r      <= '0;
      count_r     <= '0;
      thr_r       <= MERGE_RESET;
      tag_rd_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        thr_r <= cfg_data;
      end
      if (match) begin
        tag_rd_r <= '0;
      end else begin
        tag_rd_r <= iss;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      vtx_r <= in_vtx;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == ST_IDLE))
    else $error("result strobe outside idle");

  a_chain_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tag_s[NUM_AXES].valid |-> (state_r == ST_SCAN || state_r == ST_WAIT))
    else $error("chain beat outside a scan");

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MAX_CNT)
    else $error("vertex count beyond table depth");

  a_full_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.table_full) |-> (count_r == MAX_CNT))
    else $error("table full flagged with room left");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted beat did not raise busy");

endmodule

// File: tb/sv/tb_mesh_vertex_weld_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for mesh_vertex_weld_core: directed and random corners with a
// running weld predictor, one result beat checked per accepted corner.
// Depends on mvw_pkg and the mesh_vertex_weld_core RTL.
module tb_mesh_vertex_weld_core;
  import mvw_pkg::*;

  localparam int CLK_HALF     = 2;
  localparam int DRAIN_CYCLES = 32;
  localparam int COORD_HI     = 8388607;
  localparam int COORD_LO     = -8388608;
  localparam int MAX_REPORTS  = 10;
  localparam dist_t DIST_ALL  = '1;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_beat_t  in_data;
  logic      out_valid;
  out_beat_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  dist_t     cfg_data;

  coord_t    tbl_x [MAX_VERTICES];
  coord_t    tbl_y [MAX_VERTICES];
  coord_t    tbl_z [MAX_VERTICES];
  int        tbl_count;
  dist_t     merge_thr;
  out_beat_t pending_welds [$];

  bit steady;
  int mismatches;
  int corners_sent;
  int mesh_starts;
  int thr_writes;
  int appended;
  int merged;

  mesh_vertex_weld_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic out_beat_t weld_corner(in_beat_t c);
    out_beat_t r;
    longint    dx;
    longint    dy;
    longint    dz;
    bit        hit;
    r   = '0;
    hit = 1'b0;
    if (c.new_mesh) tbl_count = 0;
    if (tbl_count >= MIN_SEARCH) begin
      for (int j = 0; j < tbl_count && !hit; j++) begin
        dx = longint'(c.pos_x) - longint'(tbl_x[j]);
        dy = longint'(c.pos_y) - longint'(tbl_y[j]);
        dz = longint'(c.pos_z) - longint'(tbl_z[j]);
        if (dx * dx + dy * dy + dz * dz < longint'(merge_thr)) begin
          hit            = 1'b1;
          r.vertex_index = IDX_W'(j);
        end
      end
    end
    if (!hit) begin
      if (tbl_count < MAX_VERTICES) begin
        tbl_x[tbl_count] = c.pos_x;
        tbl_y[tbl_count] = c.pos_y;
        tbl_z[tbl_count] = c.pos_z;
        r.vertex_index   = IDX_W'(tbl_count);
        r.is_new         = 1'b1;
        tbl_count++;
      end else begin
        r.table_full = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic in_beat_t corner(bit nm, coord_t x, coord_t y, coord_t z);
    in_beat_t c;
    c.new_mesh = nm;
    c.pos_x    = x;
    c.pos_y    = y;
    c.pos_z    = z;
    return c;
  endfunction

  function automatic coord_t nudge(coord_t base, int span);
    int v;
    v = int'(base) + int'($urandom_range(0, 2 * span)) - span;
    if (v > COORD_HI) v = COORD_HI;
    if (v < COORD_LO) v = COORD_LO;
    return coord_t'(v);
  endfunction

  function automatic in_beat_t random_corner(bit nm);
    in_beat_t c;
    int       pick;
    int       span;
    int       j;
    pick = $urandom_range(0, 99);
    case ($urandom_range(0, 4))
      0: span = 0;
      1: span = 2;
      2: span = 5;
      3: span = 12;
      default: span = 300;
    endcase
    if (pick < 65 && tbl_count > 0) begin
      j = $urandom_range(0, tbl_count - 1);
      c = corner(nm, nudge(tbl_x[j], span), nudge(tbl_y[j], span), nudge(tbl_z[j], span));
    end else if (pick < 82) begin
      c = corner(nm, nudge('0, 16384), nudge('0, 16384), nudge('0, 16384));
    end else begin
      c = corner(nm, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
    end
    if (!nm && $urandom_range(0, 99) < 3) c.new_mesh = 1'b1;
    return c;
  endfunction

  function automatic dist_t pick_threshold();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return MERGE_RESET;
      2: return dist_t'($urandom_range(1, 200));
      3: return dist_t'(1) << $urandom_range(4, 20);
      4: return DIST_ALL;
      default: return dist_t'({$urandom, $urandom});
    endcase
  endfunction

  task automatic note_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%0t: %s", $time, msg);
  endtask

  always @(posedge clk) begin : check_welds
    out_beat_t want;
    if (rst_n && out_valid) begin
      if (pending_welds.size() == 0) begin
        note_mismatch($sformatf("result beat with none pending: index %0d new %0b full %0b",
                                out_data.vertex_index, out_data.is_new, out_data.table_full));
      end else begin
        want = pending_welds.pop_front();
        if (want.is_new) appended++;
        else if (!want.table_full) merged++;
        if (out_data.vertex_index !== want.vertex_index || out_data.is_new !== want.is_new ||
            out_data.table_full !== want.table_full) begin
          note_mismatch($sformatf(
              "index exp %0d act %0d, new exp %0b act %0b, full exp %0b act %0b",
              want.vertex_index, out_data.vertex_index, want.is_new,
              out_data.is_new, want.table_full, out_data.table_full));
        end
      end
    end
  end

  task automatic send_corner(in_beat_t c);
    @(negedge clk);
    start   <= 1'b1;
    in_data <= c;
    do @(posedge clk); while (busy);
    pending_welds = {pending_welds, weld_corner(c)};
    corners_sent++;
    if (c.new_mesh) mesh_starts++;
    if (!steady && $urandom_range(0, 99) < 33) begin
      @(negedge clk);
      start <= 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
    end
  endtask

  task automatic drain_welds();
    @(negedge clk);
    start <= 1'b0;
    while (pending_welds.size() != 0) @(posedge clk);
  endtask

  task automatic set_merge_threshold(dist_t v);
    drain_welds();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    merge_thr = v;
    thr_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // first three corners append without search, even when identical
  task automatic test_mesh_start();
    send_corner(corner(1'b1, 0, 0, 0));
    send_corner(corner(1'b0, 0, 0, 0));
    send_corner(corner(1'b0, 0, 0, 0));
    send_corner(corner(1'b0, 2, 2, 3));
    send_corner(corner(1'b0, 2, 2, 2));
    send_corner(corner(1'b1, 0, 0, 0));
  endtask

  task automatic test_coord_extremes();
    coord_t hi;
    coord_t lo;
    hi = coord_t'(COORD_HI);
    lo = coord_t'(COORD_LO);
    set_merge_threshold(DIST_ALL);
    send_corner(corner(1'b1, hi, hi, hi));
    send_corner(corner(1'b0, lo, lo, lo));
    send_corner(corner(1'b0, hi, lo, 0));
    send_corner(corner(1'b0, lo, lo, lo));
    set_merge_threshold('0);
    send_corner(corner(1'b0, lo, lo, lo));
    send_corner(corner(1'b0, 24'sh555555, 24'shAAAAAA, 24'sh555555));
    set_merge_threshold(dist_t'(1));
    send_corner(corner(1'b0, lo, lo, lo));
    send_corner(corner(1'b0, coord_t'(COORD_LO + 1), lo, lo));
    send_corner(corner(1'b0, 24'shAAAAAA, 24'sh555555, 24'shAAAAAA));
  endtask

  // distance exactly at threshold misses; lowest matching index wins
  task automatic test_threshold_edge();
    set_merge_threshold(dist_t'(100));
    send_corner(corner(1'b1, 0, 0, 0));
    send_corner(corner(1'b0, 1000, 0, 0));
    send_corner(corner(1'b0, 0, 1000, 0));
    send_corner(corner(1'b0, 10, 0, 0));
    send_corner(corner(1'b0, 7, 7, 1));
    send_corner(corner(1'b0, 5, 0, 0));
    send_corner(corner(1'b0, 12, 0, 0));
  endtask

  task automatic test_random_meshes();
    int left;
    int len;
    for (int phase = 0; phase < 5; phase++) begin
      set_merge_threshold(phase == 0 ? MERGE_RESET : pick_threshold());
      steady = (phase == 2);
      left   = 24;
      while (left > 0) begin
        len = $urandom_range(4, 24);
        if (len > left) len = left;
        for (int k = 0; k < len; k++) send_corner(random_corner(k == 0));
        left -= len;
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    rst_n        = 1'b0;
    start        = 1'b0;
    in_data      = '0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    merge_thr    = MERGE_RESET;
    tbl_count    = 0;
    steady       = 1'b0;
    mismatches   = 0;
    corners_sent = 0;
    mesh_starts  = 0;
    thr_writes   = 0;
    appended     = 0;
    merged       = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_mesh_start();
    test_coord_extremes();
    test_threshold_edge();
    test_random_meshes();
    set_merge_threshold(MERGE_RESET);

    drain_welds();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Welded %0d corners over %0d mesh starts and %0d threshold writes.",
             corners_sent, mesh_starts, thr_writes);
    $display("Results seen: %0d appended, %0d merged, %0d mismatches.",
             appended, merged, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/mvw_pkg.sv
rtl/core/mvw_ram.sv
rtl/core/mvw_cell.sv
rtl/core/mesh_vertex_weld_core.sv
tb/sv/tb_mesh_vertex_weld_core.sv
